FILE: hw/rtl/bf3_pkg.sv
// Shared types and constants for the 3x3 RGB box filter.
// Used by the line store and the top level; no dependencies.
package bf3_pkg;

  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W  = CH_W * NUM_CH;

  localparam int CFG_W  = 12;
  localparam int CFG_AW = 1;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int ROW_W         = $clog2(MAX_HEIGHT);
  localparam int MIN_DIM       = 3;

  // nine 8-bit samples sum to at most 2295
  localparam int SUM_W = 12;

  // divide by 9: (sum * 3641) >> 15, exact for sum < 32768
  localparam int                MUL_W      = 12;
  localparam logic [MUL_W-1:0]  DIV9_MUL   = 12'd3641;
  localparam int                DIV9_SHIFT = 15;
  localparam int                PROD_W     = SUM_W + MUL_W;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

FILE: hw/rtl/bf3_line_mem.sv
// Two line stores (row two above, row just above) with registered read.
// Same-cycle read and write at one address return the written data.
// Depends on bf3_pkg.
module bf3_line_mem #(
  parameter int DEPTH = bf3_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  bf3_pkg::pix_t        wr_a_i,
  input  bf3_pkg::pix_t        wr_b_i,
  output bf3_pkg::pix_t        rd_a_o,
  output bf3_pkg::pix_t        rd_b_o
);
  import bf3_pkg::*;

  pix_t mem_a [DEPTH];
  pix_t mem_b [DEPTH];
  pix_t ra_q, rb_q;
  pix_t byp_a_q, byp_b_q;
  logic byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_a_i;
      mem_b[wr_addr_i] <= wr_b_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ra_q <= mem_a[rd_addr_i];
      rb_q <= mem_b[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i)) begin
      byp_a_q <= wr_a_i;
      byp_b_q <= wr_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (rd_addr_i == wr_addr_i);
    end
  end

  assign rd_a_o = byp_q ? byp_a_q : ra_q;
  assign rd_b_o = byp_q ? byp_b_q : rb_q;

endmodule

FILE: hw/rtl/box_filter_3x3_rgb_top.sv
// 3x3 box filter over a raster stream of RGB pixels, one item per clock while the output is not stalled.
// Result path: line read, window/sum and divide stages, each registered, after the input accept edge.
// Throughput: 1 item per cycle sustained while m_axis_tready_i is held high.
// Reset: counters, window and pipeline cleared, width 640, height 480;
// line stores are not cleared and hold garbage until written.
module box_filter_3x3_rgb_top #(
  parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bf3_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [bf3_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [bf3_pkg::PIX_W-1:0]   s_axis_tdata_i,  // blue, green, red
  input  logic                        s_axis_tuser_i,  // frame_start
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [bf3_pkg::PIX_W-1:0]   m_axis_tdata_o,  // blue_avg, green_avg, red_avg
  output logic                        m_axis_tlast_o   // frame_end
);
  import bf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  // configuration
  logic [CFG_W-1:0] fw_q, fh_q;
  logic [XW-1:0]    fw_x, w_used;
  logic [CFG_W-1:0] h_used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= WIDTH_RESET;
      fh_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FRAME_WIDTH:  fw_q <= cfg_wdata_i;
        REG_FRAME_HEIGHT: fh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_x   = XW'(fw_q);
    w_used = fw_x;
    if (fw_x < XW'(MIN_DIM)) begin
      w_used = XW'(MIN_DIM);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      w_used = XW'(MAX_WIDTH);
    end
    h_used = fh_q;
    if (fh_q < CFG_W'(MIN_DIM)) begin
      h_used = CFG_W'(MIN_DIM);
    end else if (fh_q > CFG_W'(MAX_HEIGHT)) begin
      h_used = CFG_W'(MAX_HEIGHT);
    end
  end

  // handshake chain
  logic in_fire, fire1, fire2;
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s2_free, out_free;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s2_free         = !s2_valid_q || out_free;
  assign s_axis_tready_o = !s1_valid_q || s2_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign fire1           = s1_valid_q && s2_free;
  assign fire2           = s2_valid_q && out_free;

  // position counters
  logic [CW-1:0]    col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [XW-1:0]    col_x;
  logic [CFG_W-1:0] row_x;
  logic             col_last, row_last, has_res, frame_end;

  always_comb begin
    col_cur  = s_axis_tuser_i ? '0 : col_q;
    row_cur  = s_axis_tuser_i ? '0 : row_q;
    col_x    = XW'(col_cur);
    row_x    = CFG_W'(row_cur);
    col_last = (col_x + XW'(1)) >= w_used;
    row_last = (row_x + CFG_W'(1)) >= h_used;
    has_res  = (col_cur >= CW'(2)) && (row_cur >= ROW_W'(2));
    frame_end = (row_x == h_used - CFG_W'(1)) && (col_x == w_used - XW'(1));
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_d = col_cur + CW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line store read
  pix_t          s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_res_q, s1_end_q;
  pix_t          up2, up1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (fire1) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= s_axis_tdata_i;
      s1_col_q <= col_cur;
      s1_res_q <= has_res;
      s1_end_q <= frame_end;
    end
  end

  bf3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_cur),
    .wr_en_i   (fire1),
    .wr_addr_i (s1_col_q),
    .wr_a_i    (up1),
    .wr_b_i    (s1_pix_q),
    .rd_a_o    (up2),
    .rd_b_o    (up1)
  );

  // stage 2: window shift and channel sums
  pix_t             win_q [9];
  pix_t             win_d [9];
  logic [SUM_W-1:0] sum_d  [NUM_CH];
  logic [SUM_W-1:0] s2_sum_q [NUM_CH];
  logic             s2_end_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = up2;
    win_d[5] = up1;
    win_d[8] = s1_pix_q;
    for (int c = 0; c < NUM_CH; c++) begin
      sum_d[c] = '0;
      for (int i = 0; i < 9; i++) begin
        sum_d[c] = sum_d[c] + SUM_W'(win_d[i][c*CH_W +: CH_W]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (fire1) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (fire1) begin
      s2_valid_q <= s1_res_q;
    end else if (fire2) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s2_sum_q[c] <= sum_d[c];
      end
      s2_end_q <= s1_end_q;
    end
  end

  // output stage: divide by 9
  logic [PROD_W-1:0] prod [NUM_CH];
  pix_t              out_data_q;
  logic              out_last_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = PROD_W'(s2_sum_q[c]) * PROD_W'(DIV9_MUL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire2) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire2) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_data_q[c*CH_W +: CH_W] <= prod[c][DIV9_SHIFT +: CH_W];
      end
      out_last_q <= s2_end_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // checks
  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted item missing from stage 1");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty stage 1");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(col_q) < XW'(MAX_WIDTH))
    else $error("column counter out of line store range");

  a_s2_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 |=> m_axis_tvalid_o)
    else $error("result lost between sum and output stage");

endmodule
